/* rtl/ptt_pkg.sv */
// Shared types, constants and helpers for the probe tag table.
package ptt_pkg;

  localparam int SLOTS_DEF = 64;
  localparam int FUNC_W    = 2;
  localparam int TAG_W     = 16;
  localparam int SLOT_W    = 6;
  localparam int FLIGHT_W  = 7;
  localparam int ENTRY_W   = TAG_W + 1;
  localparam int FLIGHT_MAX = (1 << FLIGHT_W) - 1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC  = 2'd0,
    FUNC_LOOKUP = 2'd1,
    FUNC_FREE   = 2'd2
  } func_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DECODE,
    ST_SCAN,
    ST_FREE,
    ST_DONE
  } state_e;

  typedef enum logic [1:0] {
    RES_NONE,
    RES_MISS,
    RES_SCAN,
    RES_FREE
  } res_sel_e;

  typedef struct packed {
    logic     in_rdy;
    logic     clr;
    logic     scan;
    logic     rd_free;
    logic     wr_free;
    logic     alloc_wr;
    res_sel_e res;
    logic     emit;
  } ptt_cmd_t;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic              in_valid;
    logic              clr_last;
    logic              id_reject;
    logic              fslot_oob;
    logic              hit;
    logic              chk_last;
    logic              out_free;
  } ptt_sts_t;

  function automatic logic [TAG_W-1:0] swap16(input logic [TAG_W-1:0] v);
    return {v[7:0], v[15:8]};
  endfunction

endpackage

/* rtl/ptt_if.sv */
// Channel interfaces: request, response and configuration write.
interface ptt_req_if;
  logic                       valid;
  logic                       ready;
  logic [ptt_pkg::FUNC_W-1:0] func;
  logic [ptt_pkg::TAG_W-1:0]  tag_value;
  logic                       is_icmp;
  logic [ptt_pkg::TAG_W-1:0]  reply_id;
  logic [ptt_pkg::TAG_W-1:0]  reply_sequence;
  logic [ptt_pkg::SLOT_W-1:0] free_slot;

  modport source (output valid, func, tag_value, is_icmp, reply_id, reply_sequence,
                  free_slot, input ready);
  modport sink (input valid, func, tag_value, is_icmp, reply_id, reply_sequence,
                free_slot, output ready);
endinterface

interface ptt_rsp_if;
  logic                         valid;
  logic                         ready;
  logic                         ok;
  logic [ptt_pkg::SLOT_W-1:0]   slot;
  logic [ptt_pkg::FLIGHT_W-1:0] in_flight;

  modport source (output valid, ok, slot, in_flight, input ready);
  modport sink (input valid, ok, slot, in_flight, output ready);
endinterface

interface ptt_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [ptt_pkg::TAG_W-1:0] own_id;

  modport source (output valid, own_id, input ready);
  modport sink (input valid, own_id, output ready);
endinterface

/* rtl/ptt_ram.sv */
// Generic single-port RAM with registered read.
module ptt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk_i,
  input  logic                                  en_i,
  input  logic                                  we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  logic [WIDTH-1:0]                      wdata_i,
  output logic [WIDTH-1:0]                      rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/ptt_ctrl.sv */
// Sequencer for clearing, scanning, freeing and result hand-off.
module ptt_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptt_pkg::ptt_sts_t sts_i,
  output ptt_pkg::ptt_cmd_t cmd_o
);
  import ptt_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        cmd_o.in_rdy = 1'b1;
        if (sts_i.in_valid) begin
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        unique case (sts_i.func)
          FUNC_ALLOC: begin
            state_d = ST_SCAN;
          end
          FUNC_LOOKUP: begin
            if (sts_i.id_reject) begin
              cmd_o.res = RES_MISS;
              state_d   = ST_DONE;
            end else begin
              state_d = ST_SCAN;
            end
          end
          FUNC_FREE: begin
            if (sts_i.fslot_oob) begin
              cmd_o.res = RES_MISS;
              state_d   = ST_DONE;
            end else begin
              cmd_o.rd_free = 1'b1;
              state_d       = ST_FREE;
            end
          end
          default: begin
            cmd_o.res = RES_MISS;
            state_d   = ST_DONE;
          end
        endcase
      end
      ST_SCAN: begin
        // stop on the first hit or once the last slot is checked, otherwise keep one read in flight
        if (sts_i.hit) begin
          cmd_o.alloc_wr = (sts_i.func == FUNC_ALLOC);
          cmd_o.res      = RES_SCAN;
          state_d        = ST_DONE;
        end else if (sts_i.chk_last) begin
          cmd_o.res = RES_MISS;
          state_d   = ST_DONE;
        end else begin
          cmd_o.scan = 1'b1;
        end
      end
      ST_FREE: begin
        cmd_o.wr_free = 1'b1;
        cmd_o.res     = RES_FREE;
        state_d       = ST_DONE;
      end
      ST_DONE: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* rtl/ptt_dp.sv */
// Datapath: request capture, slot memory walk, in-use count and output register.
module ptt_dp #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  ptt_pkg::ptt_cmd_t cmd_i,
  output ptt_pkg::ptt_sts_t sts_o,
  ptt_req_if.sink           req_i,
  ptt_rsp_if.source         rsp_o,
  ptt_cfg_if.sink           cfg_i
);
  import ptt_pkg::*;

  localparam int IDX_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W  = $clog2(SLOTS + 1);
  localparam int FCMP_W = (IDX_W + 1 > SLOT_W) ? IDX_W + 1 : SLOT_W;
  localparam int SAT_W  = (CNT_W > FLIGHT_W) ? CNT_W : FLIGHT_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOTS - 1);

  logic [FUNC_W-1:0]   func_q;
  logic [TAG_W-1:0]    tag_q;
  logic                icmp_q;
  logic [TAG_W-1:0]    rid_q;
  logic [TAG_W-1:0]    rseq_q;
  logic [SLOT_W-1:0]   fslot_q;
  logic [TAG_W-1:0]    own_id_q;
  logic [IDX_W-1:0]    addr_q, addr_d;
  logic                addr_end_q, addr_end_d;
  logic [IDX_W-1:0]    chk_addr_q;
  logic                chk_vld_q;
  logic [CNT_W-1:0]    used_q, used_d;
  logic                res_ok_q;
  logic [IDX_W-1:0]    res_slot_q;
  logic                out_valid_q;
  logic                out_ok_q;
  logic [SLOT_W-1:0]   out_slot_q;
  logic [FLIGHT_W-1:0] out_flight_q;

  logic                ram_en, ram_we;
  logic [IDX_W-1:0]    ram_addr;
  logic [ENTRY_W-1:0]  ram_wdata, ram_rdata;
  logic                issue;
  logic [IDX_W-1:0]    fslot_idx;
  logic                ent_valid;
  logic [TAG_W-1:0]    ent_tag;
  logic                hit;
  logic [FLIGHT_W-1:0] flight;
  logic                accept;

  assign accept      = req_i.valid && cmd_i.in_rdy;
  assign req_i.ready = cmd_i.in_rdy;
  assign cfg_i.ready = 1'b1;
  assign fslot_idx   = IDX_W'(fslot_q);
  assign ent_valid   = ram_rdata[ENTRY_W-1];
  assign ent_tag     = ram_rdata[TAG_W-1:0];

  // one port: clear sweep, scan read, free read-modify-write or allocate write
  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = addr_q;
    ram_wdata = '0;
    issue     = 1'b0;
    if (cmd_i.clr) begin
      ram_en = 1'b1;
      ram_we = 1'b1;
    end else if (cmd_i.scan && !addr_end_q) begin
      ram_en = 1'b1;
      issue  = 1'b1;
    end else if (cmd_i.rd_free) begin
      ram_en   = 1'b1;
      ram_addr = fslot_idx;
    end else if (cmd_i.wr_free) begin
      ram_en   = 1'b1;
      ram_we   = 1'b1;
      ram_addr = fslot_idx;
    end else if (cmd_i.alloc_wr) begin
      ram_en    = 1'b1;
      ram_we    = 1'b1;
      ram_addr  = chk_addr_q;
      ram_wdata = {1'b1, tag_q};
    end
  end

  ptt_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .en_i    (ram_en),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    if (func_q == FUNC_ALLOC) begin
      hit = chk_vld_q && !ent_valid;
    end else begin
      hit = chk_vld_q && ent_valid && (swap16(ent_tag) == rseq_q);
    end
  end

  always_comb begin
    addr_d     = addr_q;
    addr_end_d = addr_end_q;
    if (accept) begin
      addr_d     = '0;
      addr_end_d = 1'b0;
    end else if (cmd_i.clr || issue) begin
      addr_d     = addr_q + IDX_W'(1);
      addr_end_d = (addr_q == LAST_IDX);
    end
  end

  always_comb begin
    used_d = used_q;
    if (cmd_i.alloc_wr) begin
      used_d = used_q + CNT_W'(1);
    end else if (cmd_i.wr_free && ent_valid) begin
      used_d = used_q - CNT_W'(1);
    end
  end

  always_comb begin
    if (SAT_W'(used_q) > SAT_W'(FLIGHT_MAX)) begin
      flight = FLIGHT_W'(FLIGHT_MAX);
    end else begin
      flight = FLIGHT_W'(used_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_id_q    <= '0;
      addr_q      <= '0;
      addr_end_q  <= 1'b0;
      chk_vld_q   <= 1'b0;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_i.valid) begin
        own_id_q <= cfg_i.own_id;
      end
      addr_q     <= addr_d;
      addr_end_q <= addr_end_d;
      chk_vld_q  <= issue;
      used_q     <= used_d;
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= req_i.func;
      tag_q   <= req_i.tag_value;
      icmp_q  <= req_i.is_icmp;
      rid_q   <= req_i.reply_id;
      rseq_q  <= req_i.reply_sequence;
      fslot_q <= req_i.free_slot;
    end
    if (issue) begin
      chk_addr_q <= addr_q;
    end
    unique case (cmd_i.res)
      RES_NONE: begin
      end
      RES_MISS: begin
        res_ok_q   <= 1'b0;
        res_slot_q <= '0;
      end
      RES_SCAN: begin
        res_ok_q   <= 1'b1;
        res_slot_q <= chk_addr_q;
      end
      RES_FREE: begin
        res_ok_q   <= 1'b1;
        res_slot_q <= fslot_idx;
      end
      default: begin
      end
    endcase
    if (cmd_i.emit) begin
      out_ok_q     <= res_ok_q;
      out_slot_q   <= SLOT_W'(res_slot_q);
      out_flight_q <= flight;
    end
  end

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.ok        = out_ok_q;
  assign rsp_o.slot      = out_slot_q;
  assign rsp_o.in_flight = out_flight_q;

  assign sts_o.func      = func_q;
  assign sts_o.in_valid  = req_i.valid;
  assign sts_o.clr_last  = (addr_q == LAST_IDX);
  assign sts_o.id_reject = icmp_q && (rid_q != own_id_q);
  assign sts_o.fslot_oob = (FCMP_W'(fslot_q) >= FCMP_W'(SLOTS));
  assign sts_o.hit       = hit;
  assign sts_o.chk_last  = chk_vld_q && (chk_addr_q == LAST_IDX);
  assign sts_o.out_free  = !out_valid_q || rsp_o.ready;

  a_alloc_into_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_wr |-> chk_vld_q && !ent_valid)
    else $error("allocate write into an occupied slot");

  a_emit_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> !out_valid_q || rsp_o.ready)
    else $error("result overwrites an untaken transaction");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    SAT_W'(used_q) <= SAT_W'(SLOTS))
    else $error("in-use count beyond table size");

  a_free_decrements: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.wr_free && ent_valid |=> used_q == $past(used_q) - CNT_W'(1))
    else $error("free of a used slot did not drop the count");

endmodule

/* rtl/probe_tag_table.sv */
// Top level of the probe tag table: sequencer plus datapath.
//
//  channel | dir | fields                                              | transaction when
//  req_i   | in  | func tag_value is_icmp reply_id reply_sequence free_slot | valid & ready
//  rsp_o   | out | ok slot in_flight                                   | valid & ready
//  cfg_i   | in  | own_id                                              | valid (ready tied high)
//
// After reset the slot memory is swept clear, one entry a cycle;
// req_i.ready stays low meanwhile, configuration writes are taken throughout.
// Allocate and lookup walk the single-port slot memory one entry per cycle.
// Free reads its slot and then clears it; rejected requests go straight to the result.
// The result sits in an output register; the next request is taken while it waits,
// and a stalled rsp_o holds the following result in its final state.
module probe_tag_table #(
  parameter int SLOTS = ptt_pkg::SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  ptt_req_if.sink    req_i,
  ptt_rsp_if.source  rsp_o,
  ptt_cfg_if.sink    cfg_i
);
  import ptt_pkg::*;

  ptt_cmd_t cmd;
  ptt_sts_t sts;

  ptt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .sts_i  (sts),
    .cmd_o  (cmd)
  );

  ptt_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .req_i  (req_i),
    .rsp_o  (rsp_o),
    .cfg_i  (cfg_i)
  );

endmodule
